>>> src/hls2rgb_pkg.sv
// Shared constants and types for the HLS to RGB converter.
// Depends on nothing; used by hls_to_rgb_converter.
package hls2rgb_pkg;

  localparam int unsigned HLS_MAX  = 240;
  localparam int unsigned HLS_HALF = HLS_MAX / 2;
  localparam int unsigned HUE_SIX  = HLS_MAX / 6;          // 40, ramp length
  localparam int unsigned HUE_TWO3 = (HLS_MAX * 2) / 3;    // 160, end of falling ramp
  localparam int unsigned HUE_THRD = HLS_MAX / 3;          // 80, red/blue hue offset

  // x / 240 for x < 2**16 as (x * RECIP240) >> RECIP240_SH
  localparam int unsigned RECIP240    = 69906;
  localparam int unsigned RECIP240_SH = 24;
  // x / 40 for x < 2**14 as (x * RECIP40) >> RECIP40_SH
  localparam int unsigned RECIP40     = 26215;
  localparam int unsigned RECIP40_SH  = 20;

  // Hue ramp segment of one channel
  typedef logic [1:0] seg_t;
  localparam seg_t SEG_RISE = 2'd0;
  localparam seg_t SEG_HIGH = 2'd1;
  localparam seg_t SEG_FALL = 2'd2;
  localparam seg_t SEG_LOW  = 2'd3;

endpackage

>>> src/hls_to_rgb_converter.sv
// HLS to RGB converter, six register stages plus an output skid buffer.
// Depends on hls2rgb_pkg (constants and segment codes).
//
//  channel | dir | handshake          | word (lowest bit up)
//  --------+-----+--------------------+-----------------------------------
//  in_     | in  | in_tvalid/tready   | hue[7:0], lightness[7:0], saturation[7:0]
//  out_    | out | out_tvalid/tready  | red[7:0], green[7:0], blue[7:0]
//
// One word is taken every clock while the skid register is empty; it then
// moves through s1 to s5 and into the output register. The pipeline
// runs as long as the skid register is empty, so in_tready is a flop
// output and never a function of out_tready.
// A stalled output word parks in the output register, the next one in the
// skid register; nothing is dropped or repeated. Reset (rst_n low, sync)
// clears all valid bits; data registers are not reset.
module hls_to_rgb_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // hue[7:0], lightness[15:8], saturation[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  localparam int unsigned NCH = 3; // red, green, blue

  // ---------------------------------------------------------------------
  // pipeline advance: everything moves while the skid register is free
  // ---------------------------------------------------------------------
  logic en;
  logic skid_valid_r;
  assign en        = !skid_valid_r;
  assign in_tready = en;

  // ---------------------------------------------------------------------
  // Stage 1: clamp, first product for the high level, hue offsets
  // ---------------------------------------------------------------------
  logic [7:0]  hue_in, lum_in, sat_in;
  logic [7:0]  lum_c, sat_c;
  logic        small_c;
  logic [8:0]  mop_c;
  logic [16:0] prod1_c;
  logic [8:0]  hr9_c;
  logic [7:0]  hue_c [NCH];

  assign hue_in = in_tdata[7:0];
  assign lum_in = in_tdata[15:8];
  assign sat_in = in_tdata[23:16];

  always_comb begin
    lum_c   = (lum_in > 8'(hls2rgb_pkg::HLS_MAX)) ? 8'(hls2rgb_pkg::HLS_MAX) : lum_in;
    sat_c   = (sat_in > 8'(hls2rgb_pkg::HLS_MAX)) ? 8'(hls2rgb_pkg::HLS_MAX) : sat_in;
    small_c = (lum_c <= 8'(hls2rgb_pkg::HLS_HALF));
    // dark half: lum*(240+sat); bright half: lum*sat
    mop_c   = small_c ? (9'(hls2rgb_pkg::HLS_MAX) + {1'b0, sat_c}) : {1'b0, sat_c};
    prod1_c = {9'b0, lum_c} * {8'b0, mop_c};
    // red: hue+80 wrapped once
    hr9_c   = {1'b0, hue_in} + 9'(hls2rgb_pkg::HUE_THRD);
    hue_c[0] = (hr9_c > 9'(hls2rgb_pkg::HLS_MAX)) ?
               8'(hr9_c - 9'(hls2rgb_pkg::HLS_MAX)) : hr9_c[7:0];
    // green: hue wrapped once (241..255 fold back)
    hue_c[1] = (hue_in > 8'(hls2rgb_pkg::HLS_MAX)) ?
               (hue_in - 8'(hls2rgb_pkg::HLS_MAX)) : hue_in;
    // blue: hue-80, or hue+160 below 80
    hue_c[2] = (hue_in >= 8'(hls2rgb_pkg::HUE_THRD)) ?
               (hue_in - 8'(hls2rgb_pkg::HUE_THRD)) :
               (hue_in + 8'(hls2rgb_pkg::HLS_MAX - hls2rgb_pkg::HUE_THRD));
  end

  logic        s1_valid_r;
  logic [15:0] s1_q_r;       // product + rounding half
  logic [7:0]  s1_lum_r, s1_sat_r;
  logic        s1_small_r, s1_grey_r;
  logic [7:0]  s1_hue_r [NCH];

  // ---------------------------------------------------------------------
  // Stage 2: divide by 240 through reciprocal multiply
  // ---------------------------------------------------------------------
  logic [32:0] prod2_c;
  assign prod2_c = {17'b0, s1_q_r} * 33'(hls2rgb_pkg::RECIP240);

  logic        s2_valid_r;
  logic [7:0]  s2_quot_r;
  logic [7:0]  s2_lum_r, s2_sat_r;
  logic        s2_small_r, s2_grey_r;
  logic [7:0]  s2_hue_r [NCH];

  // ---------------------------------------------------------------------
  // Stage 3: high/low levels, span, ramp segment per channel
  // ---------------------------------------------------------------------
  logic [8:0] hi9_c, lo9_c;
  logic [7:0] hi_c, lo_c, span_c;
  hls2rgb_pkg::seg_t seg_c [NCH];
  logic [5:0] t_c [NCH];

  always_comb begin
    hi9_c  = s2_small_r ? {1'b0, s2_quot_r} :
             ({1'b0, s2_lum_r} + {1'b0, s2_sat_r} - {1'b0, s2_quot_r});
    lo9_c  = {s2_lum_r, 1'b0} - hi9_c;
    hi_c   = hi9_c[7:0];
    lo_c   = lo9_c[7:0];
    span_c = hi_c - lo_c;
    for (int c = 0; c < NCH; c++) begin
      if (s2_hue_r[c] < 8'(hls2rgb_pkg::HUE_SIX)) begin
        seg_c[c] = hls2rgb_pkg::SEG_RISE;
        t_c[c]   = s2_hue_r[c][5:0];
      end else if (s2_hue_r[c] < 8'(hls2rgb_pkg::HLS_HALF)) begin
        seg_c[c] = hls2rgb_pkg::SEG_HIGH;
        t_c[c]   = '0;
      end else if (s2_hue_r[c] < 8'(hls2rgb_pkg::HUE_TWO3)) begin
        seg_c[c] = hls2rgb_pkg::SEG_FALL;
        t_c[c]   = 6'(8'(hls2rgb_pkg::HUE_TWO3) - s2_hue_r[c]);
      end else begin
        seg_c[c] = hls2rgb_pkg::SEG_LOW;
        t_c[c]   = '0;
      end
    end
  end

  logic              s3_valid_r;
  logic [7:0]        s3_hi_r, s3_lo_r, s3_span_r, s3_lum_r;
  logic              s3_grey_r;
  hls2rgb_pkg::seg_t s3_seg_r [NCH];
  logic [5:0]        s3_t_r [NCH];

  // ---------------------------------------------------------------------
  // Stage 4: span * ramp position + rounding half
  // ---------------------------------------------------------------------
  logic [13:0] m4_c [NCH];
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      m4_c[c] = 14'({6'b0, s3_span_r} * {8'b0, s3_t_r[c]}) +
                14'(hls2rgb_pkg::HUE_SIX / 2);
    end
  end

  logic              s4_valid_r;
  logic [7:0]        s4_hi_r, s4_lo_r, s4_lum_r;
  logic              s4_grey_r;
  hls2rgb_pkg::seg_t s4_seg_r [NCH];
  logic [13:0]       s4_m_r [NCH];

  // ---------------------------------------------------------------------
  // Stage 5: divide by 40 through reciprocal multiply
  // ---------------------------------------------------------------------
  logic [28:0] p5_c [NCH];
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      p5_c[c] = {15'b0, s4_m_r[c]} * 29'(hls2rgb_pkg::RECIP40);
    end
  end

  logic              s5_valid_r;
  logic [7:0]        s5_hi_r, s5_lo_r, s5_lum_r;
  logic              s5_grey_r;
  hls2rgb_pkg::seg_t s5_seg_r [NCH];
  logic [7:0]        s5_d_r [NCH];

  // ---------------------------------------------------------------------
  // Stage 6: pick level, rescale 0..240 -> 0..255 (255/240 = 17/16)
  // grey: floor(l*17/16); colour: round(l*17/16)
  // ---------------------------------------------------------------------
  logic [7:0]  level_c [NCH];
  logic [11:0] sc_c [NCH];
  logic [7:0]  rgb_c [NCH];
  logic [23:0] push_data;
  logic        push;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      case (s5_seg_r[c])
        hls2rgb_pkg::SEG_RISE,
        hls2rgb_pkg::SEG_FALL: level_c[c] = s5_lo_r + s5_d_r[c];
        hls2rgb_pkg::SEG_HIGH: level_c[c] = s5_hi_r;
        default:               level_c[c] = s5_lo_r;
      endcase
      if (s5_grey_r) begin
        level_c[c] = s5_lum_r;
      end
      sc_c[c]  = {level_c[c], 4'b0} + {4'b0, level_c[c]} +
                 (s5_grey_r ? 12'd0 : 12'd8);
      rgb_c[c] = sc_c[c][11:4];
    end
  end

  assign push_data = {rgb_c[2], rgb_c[1], rgb_c[0]};
  assign push      = en && s5_valid_r;

  // ---------------------------------------------------------------------
  // Valid bits
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  // ---------------------------------------------------------------------
  // Data registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      s1_q_r     <= 16'(prod1_c + 17'(hls2rgb_pkg::HLS_HALF));
      s1_lum_r   <= lum_c;
      s1_sat_r   <= sat_c;
      s1_small_r <= small_c;
      s1_grey_r  <= (sat_c == 8'd0);

      s2_quot_r  <= 8'(prod2_c >> hls2rgb_pkg::RECIP240_SH);
      s2_lum_r   <= s1_lum_r;
      s2_sat_r   <= s1_sat_r;
      s2_small_r <= s1_small_r;
      s2_grey_r  <= s1_grey_r;

      s3_hi_r    <= hi_c;
      s3_lo_r    <= lo_c;
      s3_span_r  <= span_c;
      s3_lum_r   <= s2_lum_r;
      s3_grey_r  <= s2_grey_r;

      s4_hi_r    <= s3_hi_r;
      s4_lo_r    <= s3_lo_r;
      s4_lum_r   <= s3_lum_r;
      s4_grey_r  <= s3_grey_r;

      s5_hi_r    <= s4_hi_r;
      s5_lo_r    <= s4_lo_r;
      s5_lum_r   <= s4_lum_r;
      s5_grey_r  <= s4_grey_r;

      for (int c = 0; c < NCH; c++) begin
        s1_hue_r[c] <= hue_c[c];
        s2_hue_r[c] <= s1_hue_r[c];
        s3_seg_r[c] <= seg_c[c];
        s3_t_r[c]   <= t_c[c];
        s4_seg_r[c] <= s3_seg_r[c];
        s4_m_r[c]   <= m4_c[c];
        s5_seg_r[c] <= s4_seg_r[c];
        s5_d_r[c]   <= 8'(p5_c[c] >> hls2rgb_pkg::RECIP40_SH);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register + skid register
  // ---------------------------------------------------------------------
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;
  logic        skid_valid_nxt;
  logic [23:0] skid_data_r, skid_data_nxt;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt  = push;
        out_data_nxt   = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid register filled without an output stall");

  a_lo_below_hi: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (lo9_c <= hi9_c) && (hi9_c <= 9'(hls2rgb_pkg::HLS_MAX)))
    else $error("high/low levels out of order or range");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    s5_valid_r |-> (level_c[0] <= 8'(hls2rgb_pkg::HLS_MAX)) &&
                   (level_c[1] <= 8'(hls2rgb_pkg::HLS_MAX)) &&
                   (level_c[2] <= 8'(hls2rgb_pkg::HLS_MAX)))
    else $error("ramp level above 240");

endmodule
